### src/dual_range_window_obstacle_classifier_core_macros.svh
// Assertion macros for the obstacle classifier checker.
// Users must have clk_i and rst_ni in scope.
`ifndef DUAL_RANGE_WINDOW_OBSTACLE_CLASSIFIER_CORE_MACROS_SVH
`define DUAL_RANGE_WINDOW_OBSTACLE_CLASSIFIER_CORE_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define DRWOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property that must hold from the edge after the trigger.
`define DRWOC_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

### src/drwoc_pkg.sv
// Shared types, constants and threshold helpers for the obstacle classifier.
// No dependencies.
`timescale 1ns / 1ps

package drwoc_pkg;

  localparam int unsigned DIST_W           = 14;
  localparam int unsigned CONF_W           = 7;
  localparam int unsigned WINDOW_DEPTH_DEF = 8;

  typedef enum logic [2:0] {
    CLS_WALL    = 3'd0,
    CLS_PERSON  = 3'd1,
    CLS_CHAIR   = 3'd2,
    CLS_TABLE   = 3'd3,
    CLS_STAIRS  = 3'd4,
    CLS_DOOR    = 3'd5,
    CLS_POLE    = 3'd6,
    CLS_UNKNOWN = 3'd7
  } class_e;

  localparam logic [CONF_W-1:0] CONF_NONE   = 7'd0;
  localparam logic [CONF_W-1:0] CONF_WALL   = 7'd92;
  localparam logic [CONF_W-1:0] CONF_TABLE  = 7'd81;
  localparam logic [CONF_W-1:0] CONF_STAIRS = 7'd89;
  localparam logic [CONF_W-1:0] CONF_PERSON = 7'd87;
  localparam logic [CONF_W-1:0] CONF_CHAIR  = 7'd81;
  localparam logic [CONF_W-1:0] CONF_POLE   = 7'd78;
  localparam logic [CONF_W-1:0] CONF_DOOR   = 7'd72;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;      // shift new pair into the windows, clear accumulators
    logic accum;     // add one window tap, rotate windows
    logic var_calc;  // form variance term and height difference
    logic classify;  // run rule chain, load output register
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic accum_last;
  } dp_status_t;

  // Window-sum threshold for a mean of cm centimeters (Q10.4 samples).
  function automatic longint unsigned sum_limit(int unsigned cm, int unsigned depth);
    return longint'(cm) * 16 * longint'(depth);
  endfunction

  // Threshold on D*Q - S^2 for a variance of cm2 square centimeters.
  function automatic longint unsigned var_limit(int unsigned cm2, int unsigned depth);
    return longint'(cm2) * 256 * longint'(depth) * longint'(depth);
  endfunction

endpackage

### src/dual_range_window_obstacle_classifier_core.sv
// Top level of the dual-range window obstacle classifier.
// Depends on drwoc_pkg, drwoc_ctrl and drwoc_datapath.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one pair of lower and
//   upper distances, unsigned Q10.4 cm. Output channel (out_valid_o /
//   out_ready_i) returns one class and confidence per accepted pair.
//   classifier_enable_i is written by cfg_we_i; write it only while idle.
//   When disabled, results read class unknown with confidence zero, but the
//   windows keep filling.
// Sequence:
//   The result is registered by the classify step (ST_CLASS) after the
//   window walk (ST_ACCUM) and variance step (ST_VAR). A new pair is
//   taken only back in idle, one pair at a time; the window is walked one
//   tap per cycle through a single squarer and square-sum accumulator.
// Reset:
//   Windows clear to zero, held class is unknown with confidence zero, the
//   classifier is disabled and no result is pending.
// Stall:
//   A result waits in the output register; the next pair is still taken and
//   processed, and its classify step waits until the register drains.
`timescale 1ns / 1ps

module dual_range_window_obstacle_classifier_core import drwoc_pkg::*; #(
  parameter int unsigned WindowDepth = WINDOW_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              classifier_enable_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DIST_W-1:0] lower_distance_i,
  input  logic [DIST_W-1:0] upper_distance_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        obstacle_class_o,
  output logic [CONF_W-1:0] confidence_percent_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  drwoc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  drwoc_datapath #(
    .WindowDepth (WindowDepth)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .classifier_enable_i  (classifier_enable_i),
    .lower_distance_i     (lower_distance_i),
    .upper_distance_i     (upper_distance_i),
    .cmd_i                (cmd),
    .status_o             (status),
    .obstacle_class_o     (obstacle_class_o),
    .confidence_percent_o (confidence_percent_o)
  );

endmodule

### src/drwoc_datapath.sv
// Datapath: sample windows, sum / square-sum accumulators, variance term,
// rule chain, held class and output register. Depends on drwoc_pkg.
`timescale 1ns / 1ps

module drwoc_datapath import drwoc_pkg::*; #(
  parameter int unsigned WindowDepth = WINDOW_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              classifier_enable_i,
  input  logic [DIST_W-1:0] lower_distance_i,
  input  logic [DIST_W-1:0] upper_distance_i,
  input  dp_cmd_t           cmd_i,
  output dp_status_t        status_o,
  output logic [2:0]        obstacle_class_o,
  output logic [CONF_W-1:0] confidence_percent_o
);

  localparam int unsigned CNT_W = $clog2(WindowDepth);
  localparam int unsigned SUM_W = DIST_W + CNT_W;
  localparam int unsigned SQ_W  = 2 * DIST_W;
  localparam int unsigned Q_W   = SQ_W + CNT_W;
  localparam int unsigned VAR_W = 2 * SUM_W;

  localparam logic [SUM_W-1:0] SL20  = SUM_W'(sum_limit(20, WindowDepth));
  localparam logic [SUM_W-1:0] SL30  = SUM_W'(sum_limit(30, WindowDepth));
  localparam logic [SUM_W-1:0] SL50  = SUM_W'(sum_limit(50, WindowDepth));
  localparam logic [SUM_W-1:0] SL70  = SUM_W'(sum_limit(70, WindowDepth));
  localparam logic [SUM_W-1:0] SL80  = SUM_W'(sum_limit(80, WindowDepth));
  localparam logic [SUM_W-1:0] SL100 = SUM_W'(sum_limit(100, WindowDepth));
  localparam logic [SUM_W-1:0] SL120 = SUM_W'(sum_limit(120, WindowDepth));
  localparam logic [SUM_W-1:0] SL150 = SUM_W'(sum_limit(150, WindowDepth));
  localparam logic [VAR_W-1:0] VL10  = VAR_W'(var_limit(10, WindowDepth));
  localparam logic [VAR_W-1:0] VL20  = VAR_W'(var_limit(20, WindowDepth));
  localparam logic [VAR_W-1:0] VL50  = VAR_W'(var_limit(50, WindowDepth));

  logic [DIST_W-1:0] lwin_q [WindowDepth];
  logic [DIST_W-1:0] uwin_q [WindowDepth];
  logic [CNT_W-1:0]  cnt_q;
  logic [SUM_W-1:0]  sl_q, su_q, hd_q;
  logic [Q_W-1:0]    ql_q;
  logic [VAR_W-1:0]  v_q;
  logic              enable_q;
  class_e            held_class_q;
  logic [CONF_W-1:0] held_conf_q;
  class_e            out_class_q;
  logic [CONF_W-1:0] out_conf_q;

  logic [SQ_W-1:0]   tap_sq;
  logic [VAR_W-1:0]  dq, sl_sq, v_d;
  logic [SUM_W-1:0]  hd_d;
  logic              hit;
  class_e            rule_class;
  logic [CONF_W-1:0] rule_conf;

  // Windows: shift on load; during accumulation rotate by one so tap 0
  // walks every sample and the window is back in place after D steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WindowDepth; i++) begin
        lwin_q[i] <= '0;
        uwin_q[i] <= '0;
      end
    end else if (cmd_i.load) begin
      for (int i = 0; i < WindowDepth - 1; i++) begin
        lwin_q[i] <= lwin_q[i+1];
        uwin_q[i] <= uwin_q[i+1];
      end
      lwin_q[WindowDepth-1] <= lower_distance_i;
      uwin_q[WindowDepth-1] <= upper_distance_i;
    end else if (cmd_i.accum) begin
      for (int i = 0; i < WindowDepth - 1; i++) begin
        lwin_q[i] <= lwin_q[i+1];
        uwin_q[i] <= uwin_q[i+1];
      end
      lwin_q[WindowDepth-1] <= lwin_q[0];
      uwin_q[WindowDepth-1] <= uwin_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.accum) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  assign status_o.accum_last = (cnt_q == CNT_W'(WindowDepth - 1));

  assign tap_sq = lwin_q[0] * lwin_q[0];
  assign dq     = VAR_W'(ql_q) * VAR_W'(WindowDepth);
  assign sl_sq  = VAR_W'(sl_q) * VAR_W'(sl_q);
  assign v_d    = dq - sl_sq;
  assign hd_d   = (su_q > sl_q) ? (su_q - sl_q) : (sl_q - su_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sl_q <= '0;
      su_q <= '0;
      ql_q <= '0;
    end else if (cmd_i.accum) begin
      sl_q <= sl_q + SUM_W'(lwin_q[0]);
      su_q <= su_q + SUM_W'(uwin_q[0]);
      ql_q <= ql_q + Q_W'(tap_sq);
    end
    if (cmd_i.var_calc) begin
      v_q  <= v_d;
      hd_q <= hd_d;
    end
  end

  // Rule chain, first match wins
  always_comb begin
    hit        = 1'b1;
    rule_class = CLS_UNKNOWN;
    rule_conf  = CONF_NONE;
    priority if (sl_q < SL50 && su_q < SL50 && v_q < VL10) begin
      rule_class = CLS_WALL;   rule_conf = CONF_WALL;
    end else if (sl_q < SL70 && su_q > SL150) begin
      rule_class = CLS_TABLE;  rule_conf = CONF_TABLE;
    end else if (sl_q < SL100 && su_q < SL100 && v_q > VL50) begin
      rule_class = CLS_STAIRS; rule_conf = CONF_STAIRS;
    end else if (v_q > VL20 && v_q < VL50 && hd_q < SL30) begin
      rule_class = CLS_PERSON; rule_conf = CONF_PERSON;
    end else if (sl_q < SL80 && hd_q > SL30 && hd_q < SL80) begin
      rule_class = CLS_CHAIR;  rule_conf = CONF_CHAIR;
    end else if (sl_q < SL30 && su_q > SL80 && su_q < SL150) begin
      rule_class = CLS_POLE;   rule_conf = CONF_POLE;
    end else if (sl_q > SL50 && sl_q < SL120 && hd_q < SL20) begin
      rule_class = CLS_DOOR;   rule_conf = CONF_DOOR;
    end else begin
      hit = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      held_class_q <= CLS_UNKNOWN;
      held_conf_q  <= CONF_NONE;
    end else begin
      if (cfg_we_i) begin
        enable_q <= classifier_enable_i;
      end
      if (cmd_i.classify && enable_q && hit) begin
        held_class_q <= rule_class;
        held_conf_q  <= rule_conf;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.classify) begin
      if (!enable_q) begin
        out_class_q <= CLS_UNKNOWN;
        out_conf_q  <= CONF_NONE;
      end else if (hit) begin
        out_class_q <= rule_class;
        out_conf_q  <= rule_conf;
      end else begin
        out_class_q <= held_class_q;
        out_conf_q  <= held_conf_q;
      end
    end
  end

  assign obstacle_class_o     = out_class_q;
  assign confidence_percent_o = out_conf_q;

endmodule

### src/drwoc_ctrl.sv
// Controller FSM: sequences load, window walk, variance and classify steps,
// and owns the input/output handshakes. Depends on drwoc_pkg.
`timescale 1ns / 1ps

module drwoc_ctrl import drwoc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_VAR,
    ST_CLASS
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  // Output register can take a new result when empty or being drained
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o     = (state_q == ST_IDLE);
  assign cmd_o.load     = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.accum    = (state_q == ST_ACCUM);
  assign cmd_o.var_calc = (state_q == ST_VAR);
  assign cmd_o.classify = (state_q == ST_CLASS) && out_free;
  assign out_valid_o    = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          if (status_i.accum_last) begin
            state_q <= ST_VAR;
          end
        end
        ST_VAR: begin
          state_q <= ST_CLASS;
        end
        ST_CLASS: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (cmd_o.classify) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### src/drwoc_checker.sv
// Port-level checker for the obstacle classifier, bound to the top level.
// Depends on drwoc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "dual_range_window_obstacle_classifier_core_macros.svh"

module drwoc_checker import drwoc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [2:0]        obstacle_class_o,
  input logic [CONF_W-1:0] confidence_percent_o
);

  logic              out_stall;
  logic              in_take;
  logic              conf_legal;
  logic              class_conf_ok;
  logic [CONF_W+2:0] result;

  assign out_stall     = out_valid_o && !out_ready_i;
  assign in_take       = in_valid_i && in_ready_o;
  assign result        = {obstacle_class_o, confidence_percent_o};
  assign conf_legal    = (confidence_percent_o == CONF_NONE)   ||
                         (confidence_percent_o == CONF_WALL)   ||
                         (confidence_percent_o == CONF_TABLE)  ||
                         (confidence_percent_o == CONF_STAIRS) ||
                         (confidence_percent_o == CONF_PERSON) ||
                         (confidence_percent_o == CONF_CHAIR)  ||
                         (confidence_percent_o == CONF_POLE)   ||
                         (confidence_percent_o == CONF_DOOR);
  assign class_conf_ok = ((obstacle_class_o == CLS_UNKNOWN) ==
                          (confidence_percent_o == CONF_NONE));

  // A pending result is held until the transaction completes
  `DRWOC_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(result), "stalled result lost")

  // One pair at a time: not ready again right after an input transaction
  `DRWOC_ASSERT_NEXT(a_one_in_flight, in_take, !in_ready_o, "input taken while busy")

  // Confidence is zero or one of the rule values
  `DRWOC_ASSERT(a_conf_legal, !out_valid_o || conf_legal, "illegal confidence value")

  // Unknown class always comes with zero confidence, and vice versa
  `DRWOC_ASSERT(a_unknown_conf, !out_valid_o || class_conf_ok, "class and confidence disagree")

endmodule

bind dual_range_window_obstacle_classifier_core drwoc_checker u_drwoc_checker (.*);

### bench/tb_top.sv
// Self-checking testbench for dual_range_window_obstacle_classifier_core.
// It predicts each class and confidence result and checks it against the DUT.
// Depends on drwoc_pkg and the classifier RTL.
`timescale 1ns / 1ps

module tb_top;
  import drwoc_pkg::*;

  localparam int DEPTH = WINDOW_DEPTH_DEF;
  localparam longint unsigned DEPTH_L = DEPTH;
  localparam int DIST_MAX = (1 << DIST_W) - 1;
  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    class_e            cls;
    logic [CONF_W-1:0] conf;
  } label_t;

  typedef enum int {
    SC_WALL, SC_TABLE, SC_STAIRS, SC_PERSON, SC_CHAIR, SC_POLE, SC_DOOR,
    SC_NOISE, SC_CORNER
  } scene_e;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_enable = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [DIST_W-1:0] lower_dist = '0;
  logic [DIST_W-1:0] upper_dist = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        obstacle_class;
  logic [CONF_W-1:0] confidence;

  // Predictor state
  logic [DIST_W-1:0] lo_win [DEPTH];
  logic [DIST_W-1:0] up_win [DEPTH];
  class_e            held_cls = CLS_UNKNOWN;
  logic [CONF_W-1:0] held_conf = CONF_NONE;
  bit                model_enable = 1'b0;

  label_t expected_labels[$];
  int     fail_count = 0;
  int     cycle_count = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_toggle = 1'b0;
  bit     hold_seen = 1'b0;
  int     hold_left = 0;

  dual_range_window_obstacle_classifier_core #(
    .WindowDepth(DEPTH)
  ) u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .classifier_enable_i (cfg_enable),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .lower_distance_i    (lower_dist),
    .upper_distance_i    (upper_dist),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .obstacle_class_o    (obstacle_class),
    .confidence_percent_o(confidence)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      lo_win[i] = '0;
      up_win[i] = '0;
    end
  end

  function automatic longint unsigned mean_bound(input int unsigned cm);
    return longint'(cm) * 16 * DEPTH_L;
  endfunction

  function automatic longint unsigned var_bound(input int unsigned cm2);
    return longint'(cm2) * 256 * DEPTH_L * DEPTH_L;
  endfunction

  // Shift the pair into the windows, run the rule chain, queue the result.
  task automatic predict_label(input logic [DIST_W-1:0] lo, input logic [DIST_W-1:0] up);
    longint unsigned s_lo, s_up, sq_lo, x, spread, gap;
    label_t lbl;
    bit hit;
    class_e c;
    logic [CONF_W-1:0] cf;
    for (int i = 0; i < DEPTH - 1; i++) begin
      lo_win[i] = lo_win[i+1];
      up_win[i] = up_win[i+1];
    end
    lo_win[DEPTH-1] = lo;
    up_win[DEPTH-1] = up;
    if (!model_enable) begin
      lbl.cls = CLS_UNKNOWN;
      lbl.conf = CONF_NONE;
    end else begin
      s_lo = 0;
      s_up = 0;
      sq_lo = 0;
      for (int i = 0; i < DEPTH; i++) begin
        x = lo_win[i];
        s_lo += x;
        s_up += up_win[i];
        sq_lo += x * x;
      end
      spread = DEPTH_L * sq_lo - s_lo * s_lo;
      gap = (s_up > s_lo) ? s_up - s_lo : s_lo - s_up;
      hit = 1'b1;
      c = CLS_UNKNOWN;
      cf = CONF_NONE;
      if (s_lo < mean_bound(50) && s_up < mean_bound(50) && spread < var_bound(10)) begin
        c = CLS_WALL; cf = CONF_WALL;
      end else if (s_lo < mean_bound(70) && s_up > mean_bound(150)) begin
        c = CLS_TABLE; cf = CONF_TABLE;
      end else if (s_lo < mean_bound(100) && s_up < mean_bound(100) &&
                   spread > var_bound(50)) begin
        c = CLS_STAIRS; cf = CONF_STAIRS;
      end else if (spread > var_bound(20) && spread < var_bound(50) &&
                   gap < mean_bound(30)) begin
        c = CLS_PERSON; cf = CONF_PERSON;
      end else if (s_lo < mean_bound(80) && gap > mean_bound(30) && gap < mean_bound(80)) begin
        c = CLS_CHAIR; cf = CONF_CHAIR;
      end else if (s_lo < mean_bound(30) && s_up > mean_bound(80) &&
                   s_up < mean_bound(150)) begin
        c = CLS_POLE; cf = CONF_POLE;
      end else if (s_lo > mean_bound(50) && s_lo < mean_bound(120) &&
                   gap < mean_bound(20)) begin
        c = CLS_DOOR; cf = CONF_DOOR;
      end else begin
        hit = 1'b0;
      end
      if (hit) begin
        held_cls = c;
        held_conf = cf;
      end
      lbl.cls = held_cls;
      lbl.conf = held_conf;
    end
    expected_labels.push_back(lbl);
  endtask

  // Drive one pair; valid stays up from the first offer until the transaction.
  task automatic send_pair(input logic [DIST_W-1:0] lo, input logic [DIST_W-1:0] up);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    lower_dist = lo;
    upper_dist = up;
    do @(posedge clk); while (!in_ready);
    predict_label(lo, up);
  endtask

  task automatic wait_for_results();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_labels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_labels.size() != 0) begin
      $error("%0d expected results never arrived", expected_labels.size());
      fail_count += expected_labels.size();
      expected_labels.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input bit en);
    wait_for_results();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_enable = en;
    @(posedge clk);
    model_enable = en;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic int jitter(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic logic [DIST_W-1:0] clip_dist(input int v);
    if (v < 0) return '0;
    if (v > DIST_MAX) return '1;
    return v[DIST_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] corner_dist();
    logic [DIST_W-1:0] one_hot;
    one_hot = 1 << $urandom_range(DIST_W - 1);
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return one_hot;
      default: return ~one_hot;
    endcase
  endfunction

  // A burst of pairs aimed at one region of the rule chain.
  task automatic send_scene(input scene_e kind, input int len);
    int base_lo, base_up, lo, up;
    base_lo = 0;
    base_up = 0;
    case (kind)
      SC_WALL: begin
        base_lo = $urandom_range(700);
        base_up = $urandom_range(700);
      end
      SC_PERSON: base_lo = $urandom_range(3000, 1000);
      SC_CHAIR: begin
        base_lo = $urandom_range(1200, 300);
        base_up = $urandom_range(1250, 550);
      end
      SC_POLE: begin
        base_lo = $urandom_range(450);
        base_up = $urandom_range(2350, 1350);
      end
      SC_DOOR: begin
        base_lo = $urandom_range(1900, 850);
        base_up = jitter(280);
      end
      default: ;
    endcase
    for (int i = 0; i < len; i++) begin
      case (kind)
        SC_WALL: begin
          lo = base_lo + jitter(8);
          up = base_up + jitter(32);
        end
        SC_TABLE: begin
          lo = $urandom_range(1050);
          up = $urandom_range(DIST_MAX, 2500);
        end
        SC_STAIRS: begin
          lo = (i % 2) ? $urandom_range(1550, 1300) : $urandom_range(200);
          up = $urandom_range(1500);
        end
        SC_PERSON: begin
          // +-5.5 cm swing gives about 30 cm^2 of variance
          lo = base_lo + ((i % 2) ? 88 : -88) + jitter(4);
          up = base_lo + jitter(200);
        end
        SC_CHAIR, SC_DOOR: begin
          lo = base_lo + jitter(8);
          up = base_lo + base_up + jitter(8);
        end
        SC_POLE: begin
          lo = base_lo + jitter(8);
          up = base_up + jitter(16);
        end
        SC_NOISE: begin
          lo = $urandom_range(DIST_MAX);
          up = $urandom_range(DIST_MAX);
        end
        default: begin
          lo = corner_dist();
          up = corner_dist();
        end
      endcase
      send_pair(clip_dist(lo), clip_dist(up));
    end
  endtask

  task automatic run_scenes(input int n_items);
    int sent, len, r;
    scene_e kind;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 85) kind = scene_e'($urandom_range(SC_DOOR));
      else if (r < 93) kind = SC_NOISE;
      else kind = SC_CORNER;
      len = $urandom_range(14, 8);
      if (len > n_items - sent) len = n_items - sent;
      send_scene(kind, len);
      sent += len;
    end
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    write_enable(1'b1);
    run_scenes(210);
    write_enable(1'b0);
    run_scenes(50);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_enable(1'b0);
    // disabled: windows still fill, output is unknown / zero
    send_pair('0, '0);
    send_pair('1, '1);
    send_pair('1, '0);
    send_pair('0, '1);
    write_enable(1'b1);
    repeat (8) send_pair(14'd400, 14'd400);
    repeat (6) send_pair(14'd640, 14'd3200);
    // far readings hit no rule, the held class stays
    repeat (4) send_pair('1, '1);
    repeat (2) send_pair('0, '0);
  endtask

  task automatic test_steady_stream();
    run_random_phase(0, 0);
  endtask

  task automatic test_sender_gaps();
    run_random_phase(48, 0);
  endtask

  task automatic test_receiver_stalls();
    run_random_phase(0, 48);
  endtask

  task automatic test_both_idle();
    run_random_phase(32, 32);
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_enable(1'b1);
    hold_toggle = ~hold_toggle;
    send_scene(SC_CHAIR, 8);
    send_scene(SC_NOISE, 4);
    wait_for_results();
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 32;
    recv_stall_pct = 32;
    send_scene(SC_DOOR, 6);
    wait_for_results();
    send_scene(SC_POLE, 6);
    wait_for_results();
    send_scene(SC_STAIRS, 6);
  endtask

  // Receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    label_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_labels.size() == 0) begin
        $error("unexpected result: class %0d confidence %0d", obstacle_class, confidence);
        fail_count++;
      end else begin
        want = expected_labels.pop_front();
        if (obstacle_class !== want.cls) begin
          $error("obstacle_class: expected %0d, got %0d", want.cls, obstacle_class);
          fail_count++;
        end
        if (confidence !== want.conf) begin
          $error("confidence_percent: expected %0d, got %0d", want.conf, confidence);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_steady_stream();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_output_backpressure();
    test_drain_pause();
    wait_for_results();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
